// ===== rtl/core/bdpm_pkg.sv =====
// Shared types and constants for the Bayer dead-pixel median block.
`timescale 1ns / 1ps
`default_nettype none

package bdpm_pkg;

  // Fixed field widths of the item channels
  localparam int COORD_BITS = 16;
  localparam int FIELD_BITS = 16;
  localparam int COUNT_BITS = 4;
  localparam int CFG_IDX_BITS = 8;
  localparam int CFG_DATA_BITS = 16;

  // Eight same-colour neighbours, ranked by a 3-bit index
  localparam int NUM_LANES = 8;
  localparam int RANK_BITS = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 8'd1;

  // Register reset values
  localparam logic [COORD_BITS-1:0] RESET_IMAGE_WIDTH = 16'd4096;
  localparam logic [COORD_BITS-1:0] RESET_IMAGE_HEIGHT = 16'd3072;

  // Lane order: left, up-left, down-left, right, up-right, down-right, up, down
  typedef struct packed {
    logic [NUM_LANES-1:0]  present;
    logic                  skip;
    logic [COUNT_BITS-1:0] count;
    logic [RANK_BITS-1:0]  k_lo;
    logic [RANK_BITS-1:0]  k_hi;
  } bdpm_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/bdpm_cfg_if.sv =====
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none

interface bdpm_cfg_if
  import bdpm_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bdpm_in_if.sv =====
// Input channel: dead-pixel coordinate and its eight same-colour neighbours.
`timescale 1ns / 1ps
`default_nettype none

interface bdpm_in_if
  import bdpm_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] dead_x;
  logic [COORD_BITS-1:0] dead_y;
  logic [FIELD_BITS-1:0] left_sample;
  logic [FIELD_BITS-1:0] up_left_sample;
  logic [FIELD_BITS-1:0] down_left_sample;
  logic [FIELD_BITS-1:0] right_sample;
  logic [FIELD_BITS-1:0] up_right_sample;
  logic [FIELD_BITS-1:0] down_right_sample;
  logic [FIELD_BITS-1:0] up_sample;
  logic [FIELD_BITS-1:0] down_sample;

  modport source (
    output valid, output dead_x, output dead_y,
    output left_sample, output up_left_sample, output down_left_sample,
    output right_sample, output up_right_sample, output down_right_sample,
    output up_sample, output down_sample,
    input ready
  );
  modport sink (
    input valid, input dead_x, input dead_y,
    input left_sample, input up_left_sample, input down_left_sample,
    input right_sample, input up_right_sample, input down_right_sample,
    input up_sample, input down_sample,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/bdpm_out_if.sv =====
// Output channel: corrected value, skip flag and neighbour count.
`timescale 1ns / 1ps
`default_nettype none

interface bdpm_out_if
  import bdpm_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] corrected_value;
  logic                  skipped;
  logic [COUNT_BITS-1:0] neighbour_count;

  modport source (
    output valid, output corrected_value, output skipped, output neighbour_count,
    input ready
  );
  modport sink (
    input valid, input corrected_value, input skipped, input neighbour_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/bdpm_front.sv =====
// Border test: neighbour presence, skip flag, count and median ranks.
`timescale 1ns / 1ps
`default_nettype none

module bdpm_front
  import bdpm_pkg::*;
(
  input  wire logic [COORD_BITS-1:0] dead_x,
  input  wire logic [COORD_BITS-1:0] dead_y,
  input  wire logic [COORD_BITS-1:0] image_width,
  input  wire logic [COORD_BITS-1:0] image_height,
  output bdpm_flags_t                flags
);

  logic has_l;
  logic has_r;
  logic has_u;
  logic has_d;
  logic skip;
  logic [NUM_LANES-1:0]  present;
  logic [COUNT_BITS-1:0] count;

  // Test each side without wrap-around
  assign has_l = dead_x >= COORD_BITS'(2);
  assign has_u = dead_y >= COORD_BITS'(2);
  assign has_r = ({1'b0, dead_x} + (COORD_BITS+1)'(2)) < {1'b0, image_width};
  assign has_d = ({1'b0, dead_y} + (COORD_BITS+1)'(2)) < {1'b0, image_height};
  assign skip  = (dead_x >= image_width) || (dead_y >= image_height);

  // Presence per lane; a skipped coordinate uses no neighbour
  always_comb begin
    present = {has_d, has_u, has_r & has_d, has_r & has_u, has_r,
               has_l & has_d, has_l & has_u, has_l};
    if (skip) begin
      present = '0;
    end
  end

  // Count the neighbours in use
  always_comb begin
    count = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      count = count + COUNT_BITS'(present[i]);
    end
  end

  // Pick the sorted positions to average: 3 and 4 for eight values, else count/2 twice
  always_comb begin
    flags.present = present;
    flags.skip    = skip;
    flags.count   = count;
    if (count == COUNT_BITS'(NUM_LANES)) begin
      flags.k_lo = RANK_BITS'(3);
      flags.k_hi = RANK_BITS'(4);
    end else begin
      flags.k_lo = count[RANK_BITS:1];
      flags.k_hi = count[RANK_BITS:1];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bdpm_rank_lane.sv =====
// One ranking lane: sorted position of its own sample among the present ones.
`timescale 1ns / 1ps
`default_nettype none

module bdpm_rank_lane
  import bdpm_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int LANE = 0
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [SAMPLE_BITS-1:0] smp [NUM_LANES],
  input  wire logic [NUM_LANES-1:0]   present,
  output logic      [RANK_BITS-1:0]   rank
);

  logic [RANK_BITS-1:0] rank_next;

  // Count present samples that sort ahead; ties go to the lower lane
  always_comb begin
    rank_next = '0;
    for (int j = 0; j < NUM_LANES; j++) begin
      if (j != LANE && present[j]) begin
        if ((smp[j] < smp[LANE]) || ((smp[j] == smp[LANE]) && (j < LANE))) begin
          rank_next = rank_next + RANK_BITS'(1);
        end
      end
    end
  end

  // Hold the rank while the stage is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      rank <= rank_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bdpm_merge.sv =====
// Merge: pick the samples at the two median ranks and average them.
`timescale 1ns / 1ps
`default_nettype none

module bdpm_merge
  import bdpm_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic [SAMPLE_BITS-1:0] smp [NUM_LANES],
  input  wire logic [RANK_BITS-1:0]   rank [NUM_LANES],
  input  wire bdpm_flags_t            flags,
  output logic      [SAMPLE_BITS-1:0] median
);

  logic [SAMPLE_BITS-1:0] lo_val;
  logic [SAMPLE_BITS-1:0] hi_val;
  logic [SAMPLE_BITS:0]   sum;

  // Ranks of present lanes are distinct, so an OR of matches selects one sample
  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (flags.present[i] && (rank[i] == flags.k_lo)) begin
        lo_val = lo_val | smp[i];
      end
      if (flags.present[i] && (rank[i] == flags.k_hi)) begin
        hi_val = hi_val | smp[i];
      end
    end
  end

  // Truncated mean; equal ranks give the sample itself
  assign sum    = {1'b0, lo_val} + {1'b0, hi_val};
  assign median = sum[SAMPLE_BITS:1];

endmodule

`default_nettype wire

// ===== rtl/core/bayer_dead_pixel_median.sv =====
// Top level: dead-pixel median correction with eight parallel ranking lanes.
// An accepted item moves through the stage 1, stage 2 and output registers in order.
// Throughput: one item per cycle while results are taken; each stage is a register with its own valid,
// so an empty stage takes an item even while the output waits to be taken.
// Reset: synchronous, clears all stage valids and loads width 4096, height 3072.
`timescale 1ns / 1ps
`default_nettype none

module bayer_dead_pixel_median
  import bdpm_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  bdpm_cfg_if.sink      cfg,
  bdpm_in_if.sink       pix_in,
  bdpm_out_if.source    pix_out
);

  logic [COORD_BITS-1:0] image_width;
  logic [COORD_BITS-1:0] image_height;

  logic [SAMPLE_BITS-1:0] smp0 [NUM_LANES];
  bdpm_flags_t            flags0;

  logic                   v1;
  logic [SAMPLE_BITS-1:0] smp1 [NUM_LANES];
  bdpm_flags_t            flags1;

  logic                   v2;
  logic [SAMPLE_BITS-1:0] smp2 [NUM_LANES];
  bdpm_flags_t            flags2;
  logic [RANK_BITS-1:0]   rank2 [NUM_LANES];

  logic [SAMPLE_BITS-1:0] median;

  logic en1;
  logic en2;
  logic en3;

  // Configuration registers; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_IMAGE_WIDTH;
      image_height <= RESET_IMAGE_HEIGHT;
    end else if (cfg.valid) begin
      if (cfg.index == REG_IMAGE_WIDTH) begin
        image_width <= cfg.data;
      end
      if (cfg.index == REG_IMAGE_HEIGHT) begin
        image_height <= cfg.data;
      end
    end
  end

  // Stage enables: a stage advances when empty or when the next one advances
  assign en3 = !pix_out.valid || pix_out.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pix_in.ready = en1;

  // Keep the low sample bits, in lane order
  assign smp0[0] = pix_in.left_sample[SAMPLE_BITS-1:0];
  assign smp0[1] = pix_in.up_left_sample[SAMPLE_BITS-1:0];
  assign smp0[2] = pix_in.down_left_sample[SAMPLE_BITS-1:0];
  assign smp0[3] = pix_in.right_sample[SAMPLE_BITS-1:0];
  assign smp0[4] = pix_in.up_right_sample[SAMPLE_BITS-1:0];
  assign smp0[5] = pix_in.down_right_sample[SAMPLE_BITS-1:0];
  assign smp0[6] = pix_in.up_sample[SAMPLE_BITS-1:0];
  assign smp0[7] = pix_in.down_sample[SAMPLE_BITS-1:0];

  bdpm_front u_front (
    .dead_x       (pix_in.dead_x),
    .dead_y       (pix_in.dead_y),
    .image_width  (image_width),
    .image_height (image_height),
    .flags        (flags0)
  );

  // Stage 1: border flags and samples
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      smp1   <= smp0;
      flags1 <= flags0;
    end
  end

  // Stage 2: one ranking lane per neighbour
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    bdpm_rank_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .LANE        (g)
    ) u_lane (
      .clk     (clk),
      .en      (en2),
      .smp     (smp1),
      .present (flags1.present),
      .rank    (rank2[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      smp2   <= smp1;
      flags2 <= flags1;
    end
  end

  bdpm_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .smp    (smp2),
    .rank   (rank2),
    .flags  (flags2),
    .median (median)
  );

  // Stage 3: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (en3) begin
      pix_out.valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      pix_out.corrected_value <= FIELD_BITS'(median);
      pix_out.skipped         <= flags2.skip;
      pix_out.neighbour_count <= flags2.count;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bdpm_checker.sv =====
// Port-level checks for the dead-pixel median block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bdpm_checker
  import bdpm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [FIELD_BITS-1:0] corrected_value,
  input wire logic                  skipped,
  input wire logic [COUNT_BITS-1:0] neighbour_count
);

  // Reset empties the pipeline
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid in the cycle after reset");

  // A skipped item carries no correction and no neighbours
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && skipped) |-> (corrected_value == '0 && neighbour_count == '0))
    else $error("skipped item with a value or a count");

  // No neighbour means no value
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && neighbour_count == '0) |-> (corrected_value == '0))
    else $error("value given without neighbours");

  // The count never reaches seven or more than eight
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (neighbour_count != 4'd7 && neighbour_count <= 4'd8))
    else $error("impossible neighbour count");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(corrected_value)
      && $stable(skipped) && $stable(neighbour_count)))
    else $error("stalled result changed");

endmodule

bind bayer_dead_pixel_median bdpm_checker u_bdpm_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (pix_out.valid),
  .out_ready       (pix_out.ready),
  .corrected_value (pix_out.corrected_value),
  .skipped         (pix_out.skipped),
  .neighbour_count (pix_out.neighbour_count)
);

`default_nettype wire

// ===== tb/dead_pixel_median_checker.sv =====
// Checker for the dead-pixel median block: tracks the geometry registers, predicts and compares.
`timescale 1ns / 1ps

module dead_pixel_median_checker
  import bdpm_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  bdpm_cfg_if       cfg,
  bdpm_in_if        pix_in,
  bdpm_out_if       pix_out,
  output int        mismatches,
  output int        outstanding,
  output int        checked
);

  localparam logic [FIELD_BITS-1:0] SAMPLE_MASK = FIELD_BITS'((32'd1 << SAMPLE_BITS) - 32'd1);
  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [FIELD_BITS-1:0] value;
    logic                  skipped;
    logic [COUNT_BITS-1:0] count;
  } correction_t;

  logic [COORD_BITS-1:0] width_reg;
  logic [COORD_BITS-1:0] height_reg;
  correction_t           pending_corrections[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    checked     = 0;
    width_reg   = RESET_IMAGE_WIDTH;
    height_reg  = RESET_IMAGE_HEIGHT;
  end

  // Print one line per mismatch (up to a cap) and count every one
  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < REPORT_CAP) begin
      $display("%0t: MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // Median of the same-colour neighbours that lie inside the image
  function automatic correction_t predict_correction(input logic [COORD_BITS-1:0] x,
                                                     input logic [COORD_BITS-1:0] y,
                                                     input logic [7:0][FIELD_BITS-1:0] samp);
    correction_t           res;
    logic [7:0]            present;
    logic [FIELD_BITS-1:0] ranked[8];
    logic [FIELD_BITS-1:0] key;
    logic                  has_l, has_r, has_u, has_d;
    int                    n;
    int                    j;
    res = '0;
    n = 0;
    if (x >= width_reg || y >= height_reg) begin
      res.skipped = 1'b1;
      return res;
    end
    // The right and down tests are done at 17 bits so nothing wraps
    has_l = x >= 16'd2;
    has_r = ({1'b0, x} + 17'd2) < {1'b0, width_reg};
    has_u = y >= 16'd2;
    has_d = ({1'b0, y} + 17'd2) < {1'b0, height_reg};
    // Lane k: left, up-left, down-left, right, up-right, down-right, up, down
    present = {has_d, has_u, has_r & has_d, has_r & has_u, has_r,
               has_l & has_d, has_l & has_u, has_l};
    for (int k = 0; k < 8; k++) begin
      if (present[k]) begin
        ranked[n] = samp[k] & SAMPLE_MASK;
        n++;
      end
    end
    // Sort ascending
    for (int i = 1; i < n; i++) begin
      key = ranked[i];
      j = i - 1;
      while (j >= 0 && ranked[j] > key) begin
        ranked[j + 1] = ranked[j];
        j--;
      end
      ranked[j + 1] = key;
    end
    if (n == 8) begin
      res.value = FIELD_BITS'(({1'b0, ranked[3]} + {1'b0, ranked[4]}) >> 1);
    end else if (n > 0) begin
      res.value = ranked[n / 2];
    end
    res.count = COUNT_BITS'(n);
    return res;
  endfunction

  // Follow register writes, check results, then queue predictions for new items
  always @(posedge clk) begin : track
    correction_t want;
    logic [7:0][FIELD_BITS-1:0] samp;
    if (rst) begin
      width_reg  = RESET_IMAGE_WIDTH;
      height_reg = RESET_IMAGE_HEIGHT;
      pending_corrections.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_IMAGE_WIDTH:  width_reg = cfg.data;
          REG_IMAGE_HEIGHT: height_reg = cfg.data;
          default: ;
        endcase
      end
      if (pix_out.valid && pix_out.ready) begin
        if (pending_corrections.size() == 0) begin
          report_mismatch("result with no item pending", int'(pix_out.corrected_value), -1);
        end else begin
          want = pending_corrections.pop_front();
          checked++;
          if (pix_out.corrected_value !== want.value) begin
            report_mismatch("corrected_value", int'(pix_out.corrected_value),
                            int'(want.value));
          end
          if (pix_out.skipped !== want.skipped) begin
            report_mismatch("skipped", int'(pix_out.skipped), int'(want.skipped));
          end
          if (pix_out.neighbour_count !== want.count) begin
            report_mismatch("neighbour_count", int'(pix_out.neighbour_count),
                            int'(want.count));
          end
        end
      end
      if (pix_in.valid && pix_in.ready) begin
        samp = {pix_in.down_sample, pix_in.up_sample, pix_in.down_right_sample,
                pix_in.up_right_sample, pix_in.right_sample, pix_in.down_left_sample,
                pix_in.up_left_sample, pix_in.left_sample};
        pending_corrections.push_back(predict_correction(pix_in.dead_x, pix_in.dead_y, samp));
      end
    end
    outstanding = pending_corrections.size();
  end

endmodule

// ===== tb/bayer_dead_pixel_median_tb.sv =====
// Testbench top for the dead-pixel median block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module bayer_dead_pixel_median_tb;
  import bdpm_pkg::*;

  localparam int SAMPLE_BITS = 16;
  localparam int LATENCY = 3;
  localparam int ITEMS_PER_GEOMETRY = 230;
  localparam int NUM_GEOMETRIES = 7;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [COORD_BITS-1:0]      x;
    logic [COORD_BITS-1:0]      y;
    logic [7:0][FIELD_BITS-1:0] samp;
  } pixel_item_t;

  logic clk;
  logic rst;
  bit   quiet;
  int   idle_run;
  int   sent_items;
  int   mismatches;
  int   outstanding;
  int   checked;

  bdpm_cfg_if cfg_bus ();
  bdpm_in_if  pixel_bus ();
  bdpm_out_if result_bus ();

  bayer_dead_pixel_median #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .pix_in(pixel_bus),
    .pix_out(result_bus)
  );

  dead_pixel_median_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_check (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .pix_in(pixel_bus),
    .pix_out(result_bus),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .checked(checked)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  // Randomly stall the result side, except during quiet stretches
  initial begin : result_stalls
    int stall;
    stall = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0 && !quiet && $urandom_range(0, 99) < 25) stall = idle_len();
      if (stall > 0) begin
        result_bus.ready = 1'b0;
        stall--;
      end else begin
        result_bus.ready = 1'b1;
      end
    end
  end

  // End the run when nothing has moved for too long
  always @(posedge clk) begin
    if (rst || (cfg_bus.valid && cfg_bus.ready) || (pixel_bus.valid && pixel_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one item, with an optional gap first, and hold it until taken
  task automatic drive_pixel(input pixel_item_t it);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      pixel_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_bus.valid             = 1'b1;
    pixel_bus.dead_x            = it.x;
    pixel_bus.dead_y            = it.y;
    pixel_bus.left_sample       = it.samp[0];
    pixel_bus.up_left_sample    = it.samp[1];
    pixel_bus.down_left_sample  = it.samp[2];
    pixel_bus.right_sample      = it.samp[3];
    pixel_bus.up_right_sample   = it.samp[4];
    pixel_bus.down_right_sample = it.samp[5];
    pixel_bus.up_sample         = it.samp[6];
    pixel_bus.down_sample       = it.samp[7];
    do @(posedge clk); while (!pixel_bus.ready);
    sent_items++;
  endtask

  task automatic send_at(input int x, input int y, input logic [7:0][FIELD_BITS-1:0] samp);
    pixel_item_t it;
    it.x    = COORD_BITS'(x);
    it.y    = COORD_BITS'(y);
    it.samp = samp;
    drive_pixel(it);
  endtask

  // Hold the input idle until every result is back, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    pixel_bus.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (LATENCY + 1) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = CFG_DATA_BITS'(value);
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic write_geometry(input int w, input int h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Coordinate biased towards the borders, with some past the image
  function automatic logic [COORD_BITS-1:0] rand_coord(input int limit);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return COORD_BITS'($urandom_range(0, 3));
    if (r < 30) return COORD_BITS'(limit - 1 - int'($urandom_range(0, 3)));
    if (r < 88) return COORD_BITS'($urandom_range(0, limit - 1));
    return COORD_BITS'($urandom_range(limit, 65535));
  endfunction

  // Neighbour values: full range, narrow (many ties), extremes, or clustered
  function automatic logic [7:0][FIELD_BITS-1:0] rand_samples();
    logic [7:0][FIELD_BITS-1:0] samp;
    int mode;
    int base;
    mode = $urandom_range(0, 9);
    base = $urandom_range(0, 65535 - 63);
    for (int k = 0; k < 8; k++) begin
      case (mode)
        0, 1, 2, 3: samp[k] = FIELD_BITS'($urandom_range(0, 65535));
        4, 5:       samp[k] = FIELD_BITS'($urandom_range(0, 7));
        6:          samp[k] = $urandom_range(0, 1) ? 16'hFFFF
                                                   : FIELD_BITS'($urandom_range(65528, 65535));
        default:    samp[k] = FIELD_BITS'(base + int'($urandom_range(0, 63)));
      endcase
    end
    return samp;
  endfunction

  initial begin : stimulus
    int geo_w[NUM_GEOMETRIES];
    int geo_h[NUM_GEOMETRIES];
    int w;
    int h;
    pixel_item_t it;
    geo_w = '{4096, 5, 65535, 5, 0, 65535, 0};
    geo_h = '{3072, 5, 65535, 65535, 0, 5, 0};
    quiet = 1'b0;
    sent_items = 0;
    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data  = '0;
    pixel_bus.valid = 1'b0;
    pixel_bus.dead_x = '0;
    pixel_bus.dead_y = '0;
    pixel_bus.left_sample = '0;
    pixel_bus.up_left_sample = '0;
    pixel_bus.down_left_sample = '0;
    pixel_bus.right_sample = '0;
    pixel_bus.up_right_sample = '0;
    pixel_bus.down_right_sample = '0;
    pixel_bus.up_sample = '0;
    pixel_bus.down_sample = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int p = 0; p < NUM_GEOMETRIES; p++) begin
      // Geometry zero means a random small image
      w = (geo_w[p] == 0) ? $urandom_range(5, 64) : geo_w[p];
      h = (geo_h[p] == 0) ? $urandom_range(5, 64) : geo_h[p];
      if (p > 0) begin
        drain();
        write_geometry(w, h);
      end

      if (p == 0) begin
        // Reset geometry: interior, corners, edges, just inside, outside
        send_at(100, 100, {16'd9, 16'd3, 16'd7, 16'd1, 16'd8, 16'd2, 16'd6, 16'd5});
        send_at(200, 300, {8{16'hFFFF}});
        send_at(200, 300, {8{16'h0000}});
        send_at(0, 0, {16'd10, 16'd20, 16'd30, 16'd40, 16'd50, 16'd60, 16'd70, 16'd80});
        send_at(4095, 3071, {16'd10, 16'd20, 16'd30, 16'd40, 16'd50, 16'd60, 16'd70, 16'd80});
        send_at(1, 1, {16'hFFFF, 16'd0, 16'h8000, 16'h7FFF, 16'd1, 16'hAAAA, 16'h5555, 16'd3});
        send_at(2, 2, {16'hFFFF, 16'hFFFE, 16'hFFFD, 16'hFFFC, 16'd3, 16'd2, 16'd1, 16'd0});
        send_at(0, 500, {16'd4, 16'd4, 16'd9, 16'd1, 16'd4, 16'd9, 16'd1, 16'd7});
        send_at(500, 3071, {16'd100, 16'd90, 16'd80, 16'd70, 16'd60, 16'd50, 16'd40, 16'd30});
        send_at(4093, 3069, {16'h1234, 16'h4321, 16'hFFFF, 16'h0001, 16'h8001, 16'h7FFE, 16'd5, 16'd6});
        send_at(4094, 100, {16'd5, 16'd5, 16'd5, 16'd6, 16'd6, 16'd6, 16'd7, 16'd7});
        send_at(4096, 0, {8{16'h5A5A}});
        send_at(0, 3072, {8{16'hA5A5}});
        send_at(65535, 65535, {8{16'hFFFF}});
      end else if (p == 1) begin
        // Smallest image: border cases of a 5x5 frame
        send_at(0, 0, {16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8});
        send_at(4, 4, {16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8});
        send_at(2, 2, {16'd8, 16'd7, 16'd6, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1});
        send_at(0, 2, {16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0});
        send_at(2, 4, {16'd11, 16'd22, 16'd33, 16'd44, 16'd55, 16'd66, 16'd77, 16'd88});
        send_at(4, 0, {16'd11, 16'd22, 16'd33, 16'd44, 16'd55, 16'd66, 16'd77, 16'd88});
        send_at(3, 1, {16'd3, 16'd1, 16'd2, 16'd9, 16'd9, 16'd9, 16'd9, 16'd9});
        send_at(5, 0, {8{16'h1111}});
        send_at(0, 5, {8{16'h2222}});
      end

      // Random items, mostly inside the image and near its borders
      for (int i = 0; i < ITEMS_PER_GEOMETRY; i++) begin
        if (i % 80 == 0) quiet = ($urandom_range(0, 2) == 0);
        if (p == 2 && i == ITEMS_PER_GEOMETRY / 2) drain();
        it.x = rand_coord(w);
        it.y = rand_coord(h);
        it.samp = rand_samples();
        drive_pixel(it);
      end
    end

    quiet = 1'b0;
    drain();
    $display("Covered %0d pixel items over %0d image geometries (5x5 up to 65535x65535),",
             sent_items, NUM_GEOMETRIES);
    $display("including corners, edges, interior and off-image coordinates; %0d results checked.",
             checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
